### hw/rtl/tbrc_pkg.sv
// Shared types and constants for the track bend ratio check.
package tbrc_pkg;

	// CORDIC datapath: coordinates are scaled so that magnitudes stay below 2^40
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 44;
	localparam int SCALE_EXP    = 40;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	localparam logic signed [31:0] RATIO_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] RATIO_LO = 32'sh8000_0000;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_MIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_MAX = 1'b1;

	typedef struct packed {
		logic               compatible;
		logic signed [31:0] bend_ratio;
		logic               zero_divisor;
	} result_t;

endpackage

### hw/rtl/tbrc_cordic.sv
// Pipelined CORDIC atan2: one vectoring iteration per register stage.
module tbrc_cordic #(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS:0]   dx,
	input  logic signed [COORD_BITS:0]   dy,
	output logic        [ANGLE_BITS-1:0] angle
);

	localparam int STEPS = tbrc_pkg::CORDIC_STEPS;
	localparam int W     = tbrc_pkg::CORDIC_W;
	localparam int SHIFT = tbrc_pkg::SCALE_EXP - COORD_BITS;
	localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

	logic signed [W-1:0] xe, ye;
	logic signed [W-1:0] x_s [0:STEPS];
	logic signed [W-1:0] y_s [0:STEPS];
	logic        [31:0]  z_s [0:STEPS];
	logic                zero_s [0:STEPS];
	logic        [31:0]  z_rnd;

	assign xe = W'(dx) <<< SHIFT;
	assign ye = W'(dy) <<< SHIFT;

	// fold the left half plane by a half turn
	always_ff @(posedge clk) begin
		if (xe[W-1]) begin
			x_s[0] <= -xe;
			y_s[0] <= -ye;
			z_s[0] <= tbrc_pkg::HALF_TURN;
		end else begin
			x_s[0] <= xe;
			y_s[0] <= ye;
			z_s[0] <= '0;
		end
		zero_s[0] <= (dx == '0) && (dy == '0);
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (!y_s[i][W-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + tbrc_pkg::ATAN_TURN[i];
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - tbrc_pkg::ATAN_TURN[i];
			end
			zero_s[i+1] <= zero_s[i];
		end
	end

	assign z_rnd = z_s[STEPS] + RND;

	always_ff @(posedge clk) begin
		angle <= zero_s[STEPS] ? '0 : z_rnd[31 -: ANGLE_BITS];
	end

endmodule

### hw/rtl/tbrc_ratio.sv
// Bend angles, pipelined restoring divide, saturation and limit compare.
module tbrc_ratio #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic        [ANGLE_BITS-1:0] a_out,
	input  logic        [ANGLE_BITS-1:0] a_mid,
	input  logic        [ANGLE_BITS-1:0] a_in,
	input  logic signed [31:0]           ratio_min,
	input  logic signed [31:0]           ratio_max,
	output logic                         out_vld,
	output tbrc_pkg::result_t            res
);

	localparam int A  = ANGLE_BITS;
	localparam int NB = ANGLE_BITS + 16;

	typedef struct packed {
		logic neg;
		logic b1_neg;
		logic b1_zero;
		logic b2_zero;
	} flags_t;

	logic [A-1:0]  b1, b2, b1_mag, b2_mag;
	logic [A-1:0]  rem_s  [0:NB];
	logic [NB-1:0] nq_s   [0:NB];
	logic [A-1:0]  den_s  [0:NB];
	flags_t        flg_s  [0:NB];
	logic          vld_s  [0:NB];

	assign b1     = a_out - a_mid;
	assign b2     = a_mid - a_in;
	assign b1_mag = b1[A-1] ? -b1 : b1;
	assign b2_mag = b2[A-1] ? -b2 : b2;

	always_ff @(posedge clk) begin
		rem_s[0]         <= '0;
		nq_s[0]          <= {b1_mag, 16'h0000};
		den_s[0]         <= b2_mag;
		flg_s[0].neg     <= b1[A-1] ^ b2[A-1];
		flg_s[0].b1_neg  <= b1[A-1];
		flg_s[0].b1_zero <= (b1 == '0);
		flg_s[0].b2_zero <= (b2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	// one quotient bit per stage, magnitudes only
	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [A:0] sh;
		logic       take;

		assign sh   = {rem_s[k], nq_s[k][NB-1]};
		assign take = sh >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? A'(sh - {1'b0, den_s[k]}) : sh[A-1:0];
			nq_s[k+1]  <= {nq_s[k][NB-2:0], take};
			den_s[k+1] <= den_s[k];
			flg_s[k+1] <= flg_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// sign and saturation
	logic [63:0]        qw;
	logic signed [31:0] ratio_f1;
	logic               zd_f1, zz_f1, vld_f1;
	flags_t             fl;

	assign qw = 64'(nq_s[NB]);
	assign fl = flg_s[NB];

	always_ff @(posedge clk) begin
		zd_f1 <= fl.b2_zero;
		zz_f1 <= fl.b2_zero && fl.b1_zero;
		if (fl.b2_zero) begin
			if (fl.b1_zero) begin
				ratio_f1 <= '0;
			end else if (fl.b1_neg) begin
				ratio_f1 <= tbrc_pkg::RATIO_LO;
			end else begin
				ratio_f1 <= tbrc_pkg::RATIO_HI;
			end
		end else if (fl.neg) begin
			ratio_f1 <= (qw > 64'h8000_0000) ? tbrc_pkg::RATIO_LO : -qw[31:0];
		end else begin
			ratio_f1 <= (qw > 64'h7FFF_FFFF) ? tbrc_pkg::RATIO_HI : qw[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_f1  <= vld_s[NB];
			out_vld <= vld_f1;
		end
	end

	// limit compare, output register
	always_ff @(posedge clk) begin
		res.bend_ratio   <= ratio_f1;
		res.zero_divisor <= zd_f1;
		res.compatible   <= zd_f1 ? zz_f1
		                          : (ratio_f1 >= ratio_min) && (ratio_f1 <= ratio_max);
	end

endmodule

### hw/rtl/track_bend_ratio_check.sv
// Top level of the track bend ratio check.
//
// Takes the xy of four successive hits and judges the bend ratio of the track.
// Input: a word is taken on each rising edge with start high; busy is always
// low, so a new hit quadruple can be offered every cycle.
// Output: done is high for one cycle with compatible, bend_ratio and
// zero_divisor; the result must be taken in that cycle, there is no hold-off.
// Pipeline from start to done: one difference stage, three parallel
// 30-stage CORDIC lanes with fold and rounding stages, one bend stage,
// ANGLE_BITS + 16 divider stages (one quotient bit each) and two stages
// of saturation and limit compare.
// Throughput: one word per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 writes ratio_min, index 1 ratio_max. Write only while
// no word is in flight.
// Reset: arst_n clears all valid bits at once and restores the ratio limits
// to full range; words in flight are dropped.
module track_bend_ratio_check #(
	parameter int COORD_BITS = 24,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         first_x,
	input  logic signed [COORD_BITS-1:0]         first_y,
	input  logic signed [COORD_BITS-1:0]         second_x,
	input  logic signed [COORD_BITS-1:0]         second_y,
	input  logic signed [COORD_BITS-1:0]         third_x,
	input  logic signed [COORD_BITS-1:0]         third_y,
	input  logic signed [COORD_BITS-1:0]         fourth_x,
	input  logic signed [COORD_BITS-1:0]         fourth_y,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [tbrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [31:0]                   cfg_data,
	output logic                                 done,
	output logic                                 compatible,
	output logic signed [31:0]                   bend_ratio,
	output logic                                 zero_divisor
);

	localparam int CW   = COORD_BITS + 1;
	localparam int CLAT = tbrc_pkg::CORDIC_STEPS + 3;

	logic signed [31:0] ratio_min_q, ratio_max_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_min_q <= tbrc_pkg::RATIO_LO;
			ratio_max_q <= tbrc_pkg::RATIO_HI;
		end else if (cfg_valid) begin
			if (cfg_index == tbrc_pkg::REG_RATIO_MIN) begin
				ratio_min_q <= cfg_data;
			end else if (cfg_index == tbrc_pkg::REG_RATIO_MAX) begin
				ratio_max_q <= cfg_data;
			end
		end
	end

	// difference vectors, exact in COORD_BITS+1
	logic signed [CW-1:0] ox_s1, oy_s1, mx_s1, my_s1, ix_s1, iy_s1;

	always_ff @(posedge clk) begin
		ox_s1 <= CW'(second_x) - CW'(first_x);
		oy_s1 <= CW'(second_y) - CW'(first_y);
		mx_s1 <= CW'(third_x) - CW'(second_x);
		my_s1 <= CW'(third_y) - CW'(second_y);
		ix_s1 <= CW'(fourth_x) - CW'(third_x);
		iy_s1 <= CW'(fourth_y) - CW'(third_y);
	end

	logic [CLAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[CLAT-2:0], start};
		end
	end

	logic [ANGLE_BITS-1:0] a_out, a_mid, a_in;

	tbrc_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_out (
		.clk(clk), .dx(ox_s1), .dy(oy_s1), .angle(a_out)
	);

	tbrc_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_mid (
		.clk(clk), .dx(mx_s1), .dy(my_s1), .angle(a_mid)
	);

	tbrc_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic_in (
		.clk(clk), .dx(ix_s1), .dy(iy_s1), .angle(a_in)
	);

	tbrc_pkg::result_t res;

	tbrc_ratio #(.ANGLE_BITS(ANGLE_BITS)) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_q[CLAT-1]),
		.a_out     (a_out),
		.a_mid     (a_mid),
		.a_in      (a_in),
		.ratio_min (ratio_min_q),
		.ratio_max (ratio_max_q),
		.out_vld   (done),
		.res       (res)
	);

	assign compatible   = res.compatible;
	assign bend_ratio   = res.bend_ratio;
	assign zero_divisor = res.zero_divisor;

endmodule

### hw/rtl/tbrc_checker.sv
// Port-level checks for the track bend ratio check, bound to the top level.
module tbrc_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               compatible,
	input logic signed [31:0] bend_ratio,
	input logic               zero_divisor
);

	localparam int LAT = ANGLE_BITS + 52;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result word without a matching start");

	a_zero_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_divisor && (bend_ratio == 32'sd0) |-> compatible)
		else $error("zero over zero not accepted");

	a_zdiv_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_divisor && (bend_ratio != 32'sd0) |->
		!compatible && ((bend_ratio == tbrc_pkg::RATIO_HI) ||
		(bend_ratio == tbrc_pkg::RATIO_LO)))
		else $error("zero divisor word not saturated or accepted");

endmodule

bind track_bend_ratio_check tbrc_checker #(.ANGLE_BITS(ANGLE_BITS)) u_tbrc_checker (.*);
